/* hw/rtl/ksf_pkg.sv */
// Shared types, constants and codes of the knot span finder.
package ksf_pkg;

  // Default sizes of the knot table, the order limit and the knot width.
  localparam int MAX_KNOTS_DEF = 64;
  localparam int MAX_ORDER_DEF = 16;
  localparam int KNOT_BITS_DEF = 32;

  // Field widths of requests, results and configuration registers.
  localparam int ORDER_W    = 5;
  localparam int TOTAL_W    = 7;
  localparam int SLOT_W     = 6;
  localparam int VALUE_W    = 32;
  localparam int SPAN_W     = 7;
  localparam int MULT_W     = 7;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Smallest usable configuration.
  localparam int MIN_ORDER = 2;
  localparam int MIN_KNOTS = 4;

  // Register reset values.
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 7'd8;

  // Span code reported when no span holds the value.
  localparam logic [SPAN_W-1:0] SPAN_NONE = '1;

  // Request kinds carried on tuser.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_TOTAL  = 1'd1;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_SR_RD,
    S_SR_CMP,
    S_DN_LAST,
    S_DN,
    S_UP_RD,
    S_UP,
    S_RESULT
  } ksf_state_e;

  // Address source of the first table read port.
  typedef enum logic [2:0] {
    RSEL_LAST,
    RSEL_PTR,
    RSEL_PTR_DEC,
    RSEL_PTR_INC,
    RSEL_MID,
    RSEL_MID_Q
  } ksf_rsel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    ksf_rsel_e rsel;
    logic      wr_knot;
    logic      start_query;
    logic      mid_load;
    logic      high_load;
    logic      low_load;
    logic      hit_last;
    logic      hit_mid;
    logic      cnt_inc;
    logic      ptr_dec;
    logic      ptr_inc;
    logic      ptr_up;
    logic      out_load;
  } ksf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cfg_ok;
    logic key_eq_a;
    logic key_lt_a;
    logic key_ge_b;
    logic low_le_high;
    logic mid_is_low;
    logic ptr_zero;
    logic ptr_last;
    logic out_free;
  } ksf_stat_t;

endpackage

/* hw/rtl/ksf_ctrl.sv */
// Controller state machine of the knot span finder.
module ksf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_kind_i,
  output logic               req_ready_o,
  input  ksf_pkg::ksf_stat_t stat_i,
  output ksf_pkg::ksf_cmd_t  cmd_o
);
  import ksf_pkg::*;

  ksf_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rsel   = RSEL_PTR;
    req_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        // The table entry at the last interior span is read ahead of each request.
        req_ready_o = 1'b1;
        cmd_o.rsel  = RSEL_LAST;
        if (req_valid_i) begin
          if (req_kind_i == CMD_LOAD) begin
            cmd_o.wr_knot = 1'b1;
          end else begin
            cmd_o.start_query = 1'b1;
            state_d = stat_i.cfg_ok ? S_LAST : S_RESULT;
          end
        end
      end
      S_LAST: begin
        // A value equal to the last interior knot takes the last span.
        cmd_o.rsel = RSEL_PTR;
        if (stat_i.key_eq_a) begin
          cmd_o.hit_last = 1'b1;
          state_d = S_DN_LAST;
        end else begin
          state_d = S_SR_RD;
        end
      end
      S_SR_RD: begin
        // Read the knots at mid and mid plus one.
        cmd_o.rsel     = RSEL_MID;
        cmd_o.mid_load = 1'b1;
        state_d = stat_i.low_le_high ? S_SR_CMP : S_RESULT;
      end
      S_SR_CMP: begin
        // Narrow the interval, or take mid as the span.
        cmd_o.rsel = RSEL_MID_Q;
        if (stat_i.key_lt_a) begin
          cmd_o.high_load = 1'b1;
          state_d = S_SR_RD;
        end else if (stat_i.key_ge_b) begin
          if (stat_i.mid_is_low) begin
            state_d = S_RESULT;
          end else begin
            cmd_o.low_load = 1'b1;
            state_d = S_SR_RD;
          end
        end else begin
          cmd_o.hit_mid = 1'b1;
          state_d = S_DN;
        end
      end
      S_DN_LAST, S_DN: begin
        // Count equal knots downward, one table read per cycle.
        cmd_o.rsel = RSEL_PTR_DEC;
        if (stat_i.key_eq_a && !stat_i.ptr_zero) begin
          cmd_o.cnt_inc = 1'b1;
          cmd_o.ptr_dec = 1'b1;
        end else begin
          cmd_o.cnt_inc = stat_i.key_eq_a;
          if (state_q == S_DN_LAST) begin
            cmd_o.ptr_up = 1'b1;
            state_d = S_UP_RD;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_UP_RD: begin
        // Fetch the knot just above the span.
        cmd_o.rsel = RSEL_PTR;
        state_d = S_UP;
      end
      S_UP: begin
        // Count equal knots upward up to the end of the vector.
        cmd_o.rsel = RSEL_PTR_INC;
        if (stat_i.key_eq_a) begin
          cmd_o.cnt_inc = 1'b1;
          if (stat_i.ptr_last) begin
            state_d = S_RESULT;
          end else begin
            cmd_o.ptr_inc = 1'b1;
          end
        end else begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        // Hand the result to the output register once it has room.
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SR_CMP |-> $past(state_q) == S_SR_RD)
    else $error("search compare without a preceding table read");

  a_up_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UP |-> ($past(state_q) == S_UP_RD || $past(state_q) == S_UP))
    else $error("upward count entered without fetching the next knot");

  a_result_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESULT |=> (state_q == S_IDLE || state_q == S_RESULT))
    else $error("result state left to a state other than idle");
`endif

endmodule

/* hw/rtl/ksf_datapath.sv */
// Datapath of the knot span finder: knot table, search registers and output register.
module ksf_datapath #(
  parameter int MAX_KNOTS = ksf_pkg::MAX_KNOTS_DEF,
  parameter int MAX_ORDER = ksf_pkg::MAX_ORDER_DEF,
  parameter int KNOT_BITS = ksf_pkg::KNOT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ksf_pkg::ksf_cmd_t                    cmd_i,
  output ksf_pkg::ksf_stat_t                   stat_o,
  input  logic [ksf_pkg::ORDER_W-1:0]          curve_order_i,
  input  logic [ksf_pkg::TOTAL_W-1:0]          knot_total_i,
  input  logic [ksf_pkg::SLOT_W-1:0]           knot_slot_i,
  input  logic signed [ksf_pkg::VALUE_W-1:0]   knot_value_i,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [ksf_pkg::M_TDATA_W-1:0]        m_tdata_o
);
  import ksf_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int IW = AW + 1;
  localparam int CW = (IW > TOTAL_W) ? IW : TOTAL_W;

  logic [CW-1:0] ord_c, tot_c, last_c;
  logic          cfg_ok;

  logic signed [KNOT_BITS-1:0] key_in;
  logic signed [KNOT_BITS-1:0] key_q, key_d;
  logic signed [KNOT_BITS-1:0] mem_q [MAX_KNOTS];
  logic signed [KNOT_BITS-1:0] rd_a_q, rd_b_q;
  logic                        wr_en;

  logic [IW-1:0] ptr_q, ptr_d, low_q, low_d, high_q, high_d;
  logic [IW-1:0] mid_q, mid_d, span_q, span_d;
  logic [IW-1:0] mid_c, ra, rb;
  logic [MULT_W-1:0] cnt_q, cnt_d;
  logic              found_q, found_d;

  logic              out_valid_q, out_valid_d;
  logic [SPAN_W-1:0] out_span_q, out_span_d;
  logic [MULT_W-1:0] out_mult_q, out_mult_d;
  logic              out_found_q, out_found_d;

  // Configuration checks and the last interior span.
  assign ord_c  = CW'(curve_order_i);
  assign tot_c  = CW'(knot_total_i);
  assign last_c = tot_c - ord_c;
  assign cfg_ok = (ord_c >= CW'(MIN_ORDER)) && (ord_c <= CW'(MAX_ORDER)) &&
                  (tot_c >= CW'(MIN_KNOTS)) && (tot_c <= CW'(MAX_KNOTS)) &&
                  (tot_c > ord_c);

  // Knots are kept at table width, sign extended or truncated.
  assign key_in = KNOT_BITS'(knot_value_i);
  assign wr_en  = cmd_i.wr_knot && (int'(knot_slot_i) < MAX_KNOTS);

  // Midpoint of the search interval, rounded up.
  assign mid_c = low_q + ((high_q - low_q + IW'(1)) >> 1);

  // Read addresses.
  always_comb begin
    case (cmd_i.rsel)
      RSEL_LAST:    ra = IW'(last_c);
      RSEL_PTR:     ra = ptr_q;
      RSEL_PTR_DEC: ra = ptr_q - IW'(1);
      RSEL_PTR_INC: ra = ptr_q + IW'(1);
      RSEL_MID:     ra = mid_c;
      RSEL_MID_Q:   ra = mid_q;
      default:      ra = ptr_q;
    endcase
  end
  assign rb = mid_c + IW'(1);

  // Knot table with one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AW'(knot_slot_i)] <= key_in;
    end
    rd_a_q <= mem_q[ra[AW-1:0]];
    rd_b_q <= mem_q[rb[AW-1:0]];
  end

  // Status toward the controller.
  always_comb begin
    stat_o.cfg_ok      = cfg_ok;
    stat_o.key_eq_a    = (key_q == rd_a_q);
    stat_o.key_lt_a    = (key_q < rd_a_q);
    stat_o.key_ge_b    = (key_q >= rd_b_q);
    stat_o.low_le_high = (low_q <= high_q);
    stat_o.mid_is_low  = (mid_q == low_q);
    stat_o.ptr_zero    = (ptr_q == '0);
    stat_o.ptr_last    = ((CW'(ptr_q) + CW'(1)) == tot_c);
    stat_o.out_free    = !out_valid_q || m_tready_i;
  end

  // Search and count registers.
  always_comb begin
    key_d   = key_q;
    ptr_d   = ptr_q;
    low_d   = low_q;
    high_d  = high_q;
    mid_d   = mid_q;
    span_d  = span_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    if (cmd_i.start_query) begin
      key_d   = key_in;
      ptr_d   = IW'(last_c);
      low_d   = IW'(ord_c - CW'(1));
      high_d  = IW'(last_c);
      cnt_d   = '0;
      found_d = 1'b0;
    end
    if (cmd_i.mid_load) begin
      mid_d = mid_c;
    end
    if (cmd_i.high_load) begin
      high_d = mid_q - IW'(1);
    end
    if (cmd_i.low_load) begin
      low_d = mid_q;
    end
    if (cmd_i.hit_last) begin
      found_d = 1'b1;
      span_d  = ptr_q;
    end
    if (cmd_i.hit_mid) begin
      found_d = 1'b1;
      span_d  = mid_q;
      ptr_d   = mid_q;
    end
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + MULT_W'(1);
    end
    if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - IW'(1);
    end
    if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + IW'(1);
    end
    if (cmd_i.ptr_up) begin
      ptr_d = span_q + IW'(1);
    end
  end

  // Output register; it holds a result until the downstream side takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    out_span_d  = out_span_q;
    out_mult_d  = out_mult_q;
    out_found_d = out_found_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_span_d  = found_q ? SPAN_W'(span_q) : SPAN_NONE;
      out_mult_d  = found_q ? cnt_q : '0;
      out_found_d = found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    ptr_q       <= ptr_d;
    low_q       <= low_d;
    high_q      <= high_d;
    mid_q       <= mid_d;
    span_q      <= span_d;
    out_span_q  <= out_span_d;
    out_mult_q  <= out_mult_d;
    out_found_q <= out_found_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, out_found_q, out_mult_q, out_span_q};

`ifndef SYNTHESIS
  a_count_needs_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> found_q)
    else $error("knot count advanced without a span found");
`endif

endmodule

/* hw/rtl/nurbs_knot_span_find_unit.sv */
// Load request: writes the knot table and gives no result.
// Query request: the result is registered after a binary search and a count walk. The search has
// at most about log2(knot_total) + 1 steps, each one table read and one compare, the last only
// the read when the interval is empty. The count walk makes one table read per equal knot, plus one
// fetch on the last interior knot. An unusable configuration skips the search and reports no span.
// Queries run one at a time. Reset: controller idle, output empty, order 4, total 8, table undefined.
module nurbs_knot_span_find_unit #(
  parameter int MAX_KNOTS = ksf_pkg::MAX_KNOTS_DEF,
  parameter int MAX_ORDER = ksf_pkg::MAX_ORDER_DEF,
  parameter int KNOT_BITS = ksf_pkg::KNOT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: knot_slot[5:0], knot_value[37:6], zero pad[39:38].
  input  logic [ksf_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: cmd[0].
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: span_index[6:0], multiplicity[13:7], found[14], zero pad[15].
  output logic [ksf_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ksf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ksf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ksf_pkg::*;

  logic [ORDER_W-1:0]        curve_order_q;
  logic [TOTAL_W-1:0]        knot_total_q;
  logic [SLOT_W-1:0]         knot_slot;
  logic signed [VALUE_W-1:0] knot_value;
  ksf_cmd_t                  cmd;
  ksf_stat_t                 stat;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_order_q <= ORDER_RESET;
      knot_total_q  <= TOTAL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CURVE_ORDER: curve_order_q <= cfg_data_i[ORDER_W-1:0];
        CFG_KNOT_TOTAL:  knot_total_q  <= cfg_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Request fields.
  assign knot_slot  = s_axis_tdata[SLOT_W-1:0];
  assign knot_value = s_axis_tdata[SLOT_W +: VALUE_W];

  ksf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_kind_i  (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ksf_datapath #(
    .MAX_KNOTS (MAX_KNOTS),
    .MAX_ORDER (MAX_ORDER),
    .KNOT_BITS (KNOT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .curve_order_i (curve_order_q),
    .knot_total_i  (knot_total_q),
    .knot_slot_i   (knot_slot),
    .knot_value_i  (knot_value),
    .m_tready_i    (m_axis_tready),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tdata_o     (m_axis_tdata)
  );

endmodule
